FILE: sv/slt_pkg.sv
// Shared types and constants for the sequential list table.
// Holds the operation codes and the command and status structs between the
// controller and the datapath; depends on nothing else.
`default_nettype none

package slt_pkg;

  // Fixed field widths of the stream payload.
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SIZE_W = 8;

  // Packed payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 56;

  // Operation codes carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the incoming transaction
    logic get_rd;     // read the entry addressed by the position
    logic scan_init;  // load the walk counters for locate, insert or delete
    logic step;       // advance the walk by one entry
    logic commit;     // final write and length update of insert or delete
    logic clear;      // empty the list
    logic finish;     // load the result register
    logic err;        // result status is an error
    logic sel_rd;     // result carries the read data
    logic sel_match;  // result carries the locate position
  } slt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;         // operation of the captured transaction
    logic get_ok;     // position is inside the list
    logic ins_ok;     // position and fill level allow an insert
    logic del_ok;     // position is inside the list
    logic scan_done;  // walk finished or locate found a match
    logic out_free;   // result register can take a new result
  } slt_stat_t;

endpackage

`default_nettype wire

FILE: sv/slt_dp.sv
// Datapath of the sequential list table: element store, length counter,
// walk counters with a one-entry read pipeline, and the result register.
// Depends on slt_pkg for the command and status structs.
`default_nettype none

module slt_dp #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input payload: tdata = position[7:0], value[39:8]; tuser = operation[2:0].
  input  wire logic [slt_pkg::IN_DATA_W-1:0]   s_tdata_i,
  input  wire logic [slt_pkg::OP_W-1:0]        s_tuser_i,
  input  wire slt_pkg::slt_cmd_t               cmd_i,
  output slt_pkg::slt_stat_t                   stat_o,
  // Result: tdata = read_value[31:0], match_position[39:32],
  // list_size[47:40], is_empty[48], zero pad; tuser = status[0].
  output logic                                 m_tvalid_o,
  input  wire logic                            m_tready_i,
  output logic [slt_pkg::OUT_DATA_W-1:0]       m_tdata_o,
  output logic                                 m_tuser_o
);
  import slt_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > POS_W) ? LW : POS_W) + 1;

  // Element store, one write and one registered read per cycle.
  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  // Captured transaction.
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;

  // List length.
  logic [LW-1:0] len_q, len_d;

  // Walk counters: next read index, last read index, index of rdata_q.
  logic [CW-1:0] ra_q, ra_d;
  logic [CW-1:0] last_q, last_d;
  logic [CW-1:0] di_q, di_d;
  logic          more_q, more_d;
  logic          dv_q, dv_d;

  // Result register.
  logic             out_valid_q;
  logic             status_q;
  logic [VAL_W-1:0] rd_val_q;
  logic [SIZE_W-1:0] match_q;
  logic [SIZE_W-1:0] size_q;
  logic             empty_q;

  logic [CW-1:0] pos_w, len_w, len_d_w, pos_m1, len_m1, di_p1, di_m1;
  logic          is_loc, is_ins, is_del, loc_hit, pipe_idle;
  logic          mem_we;
  logic [CW-1:0] mem_wa;
  logic [VAL_W-1:0] mem_wd;
  logic [CW-1:0] mem_ra;

  assign pos_w   = CW'(pos_q);
  assign len_w   = CW'(len_q);
  assign len_d_w = CW'(len_d);
  assign pos_m1  = pos_w - CW'(1);
  assign len_m1  = len_w - CW'(1);
  assign di_p1   = di_q + CW'(1);
  assign di_m1   = di_q - CW'(1);

  assign is_loc = (op_q == OP_LOCATE);
  assign is_ins = (op_q == OP_INSERT);
  assign is_del = (op_q == OP_DELETE);

  // A compare hit on the entry just read ends a locate early.
  assign loc_hit   = is_loc && dv_q && (rdata_q == val_q);
  assign pipe_idle = !more_q && !dv_q;

  // Status toward the controller.
  always_comb begin
    stat_o.op        = op_e'(op_q);
    stat_o.get_ok    = (pos_w != '0) && (pos_w <= len_w);
    stat_o.ins_ok    = (pos_w != '0) && (pos_w <= len_w + CW'(1)) &&
                       (len_w < CW'(CAPACITY));
    stat_o.del_ok    = (pos_w != '0) && (pos_w <= len_w);
    stat_o.scan_done = loc_hit || pipe_idle;
    stat_o.out_free  = !out_valid_q || m_tready_i;
  end

  // Walk counters. A read is issued on each step while entries remain.
  always_comb begin
    ra_d   = ra_q;
    last_d = last_q;
    di_d   = di_q;
    more_d = more_q;
    dv_d   = dv_q;
    if (cmd_i.scan_init) begin
      dv_d = 1'b0;
      if (is_ins) begin
        ra_d   = len_m1;
        last_d = pos_m1;
        more_d = (pos_w <= len_w);
      end else if (is_del) begin
        ra_d   = pos_w;
        last_d = len_m1;
        more_d = (pos_w < len_w);
      end else begin
        ra_d   = '0;
        last_d = len_m1;
        more_d = (len_w != '0);
      end
    end else if (cmd_i.step) begin
      dv_d = more_q;
      if (more_q) begin
        di_d = ra_q;
        if (ra_q == last_q) begin
          more_d = 1'b0;
        end else if (is_ins) begin
          ra_d = ra_q - CW'(1);
        end else begin
          ra_d = ra_q + CW'(1);
        end
      end
    end
  end

  // Store port selection: moves of the walk, or the final insert write.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = di_p1;
    mem_wd = rdata_q;
    if (cmd_i.commit && is_ins) begin
      mem_we = 1'b1;
      mem_wa = pos_m1;
      mem_wd = val_q;
    end else if (cmd_i.step && dv_q && (is_ins || is_del)) begin
      mem_we = 1'b1;
      mem_wa = is_ins ? di_p1 : di_m1;
    end
    mem_ra = cmd_i.get_rd ? pos_m1 : ra_q;
  end

  // Next length.
  always_comb begin
    len_d = len_q;
    if (cmd_i.clear) begin
      len_d = '0;
    end else if (cmd_i.commit && is_ins) begin
      len_d = len_q + LW'(1);
    end else if (cmd_i.commit && is_del) begin
      len_d = len_q - LW'(1);
    end
  end

  // Element store.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa[AW-1:0]] <= mem_wd;
    end
    if (cmd_i.get_rd || (cmd_i.step && more_q)) begin
      rdata_q <= mem_q[mem_ra[AW-1:0]];
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pos_q <= s_tdata_i[POS_W-1:0];
      val_q <= s_tdata_i[POS_W +: VAL_W];
    end
    ra_q   <= ra_d;
    last_q <= last_d;
    di_q   <= di_d;
    if (cmd_i.finish) begin
      status_q <= cmd_i.err;
      rd_val_q <= cmd_i.sel_rd ? rdata_q : '0;
      match_q  <= (cmd_i.sel_match && loc_hit) ? di_p1[SIZE_W-1:0] : '0;
      size_q   <= len_d_w[SIZE_W-1:0];
      empty_q  <= (len_d == '0);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_CLEAR;
      len_q       <= '0;
      more_q      <= 1'b0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        op_q <= s_tuser_i;
      end
      len_q  <= len_d;
      more_q <= more_d;
      dv_q   <= dv_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = status_q;
  assign m_tdata_o  = {7'd0, empty_q, size_q, match_q, rd_val_q};

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || m_tready_i))
    else $error("result loaded while previous result still pending");

  // The length moves only together with a result.
  a_len_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.finish |=> $stable(len_q))
    else $error("list length changed without a result");

  // The final insert write never collides with a move of the walk.
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit && cmd_i.step))
    else $error("commit and walk step in the same cycle");

  // The length never exceeds the store.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (CW'(len_q) <= CW'(CAPACITY)))
    else $error("list length beyond capacity");

endmodule

`default_nettype wire

FILE: sv/slt_ctrl.sv
// Controller of the sequential list table: decodes each transaction and
// sequences reads, walks and result loading in the datapath.
// Depends on slt_pkg for the operation codes and command and status structs.
`default_nettype none

module slt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  input  wire slt_pkg::slt_stat_t stat_i,
  output slt_pkg::slt_cmd_t       cmd_o
);
  import slt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_GET_WAIT
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.op)
          OP_GET: begin
            if (stat_i.get_ok) begin
              cmd_o.get_rd = 1'b1;
              state_d      = ST_GET_WAIT;
            end else if (stat_i.out_free) begin
              cmd_o.finish = 1'b1;
              cmd_o.err    = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          OP_LOCATE: begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SCAN;
          end
          OP_INSERT: begin
            if (stat_i.ins_ok) begin
              cmd_o.scan_init = 1'b1;
              state_d         = ST_SCAN;
            end else if (stat_i.out_free) begin
              cmd_o.finish = 1'b1;
              cmd_o.err    = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          OP_DELETE: begin
            if (stat_i.del_ok) begin
              cmd_o.scan_init = 1'b1;
              state_d         = ST_SCAN;
            end else if (stat_i.out_free) begin
              cmd_o.finish = 1'b1;
              cmd_o.err    = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          OP_CLEAR: begin
            if (stat_i.out_free) begin
              cmd_o.clear  = 1'b1;
              cmd_o.finish = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          default: begin
            // Undefined operation codes only report an error.
            if (stat_i.out_free) begin
              cmd_o.finish = 1'b1;
              cmd_o.err    = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (!stat_i.scan_done) begin
          cmd_o.step = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.commit    = 1'b1;
          cmd_o.finish    = 1'b1;
          cmd_o.sel_match = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_GET_WAIT: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.sel_rd = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sequential_list_table.sv
// Sequential list table: ordered list of signed 32-bit values in a store of
// CAPACITY entries, one transaction at a time through one store write port
// and one read port. Clear and errors load the result from decode, get after
// its read, and locate, insert and delete after their walk of the list.
// The next transaction is taken in the cycle after the result loads.
// Reset clears the length and control state; the store holds no reset value.
`default_nettype none

module sequential_list_table #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // position[7:0], value[39:8]
  input  wire logic [slt_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // operation[2:0]
  input  wire logic [slt_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // read_value[31:0], match_position[39:32], list_size[47:40],
  // is_empty[48], zero pad [55:49]
  output logic [slt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status[0]
  output logic                               m_axis_tuser
);
  import slt_pkg::*;

  slt_cmd_t  cmd;
  slt_stat_t stat;

  // Operation sequencing.
  slt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Store, counters and result register.
  slt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
